// ===== rtl/bvlt_pkg.sv =====
// ----------------------------------------------------------------------------
// bvlt_pkg
// Shared widths, register codes and reset values for the battery voltage
// level tracker.
// ----------------------------------------------------------------------------
package bvlt_pkg;

  // Field widths
  localparam int unsigned VOLT_BITS    = 13;
  localparam int unsigned HYST_BITS    = 10;
  localparam int unsigned CNT_BITS     = 10;
  localparam int unsigned LVL_BITS     = 3;
  localparam int unsigned NUM_THRESH   = 5;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DAT_BITS = 13;

  typedef logic [VOLT_BITS-1:0] mv_t;
  typedef mv_t [NUM_THRESH-1:0] thr_arr_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HYST     = 3'd0,
    REG_DEBOUNCE = 3'd1,
    REG_TH_ONE   = 3'd2,
    REG_TH_TWO   = 3'd3,
    REG_TH_THREE = 3'd4,
    REG_TH_FOUR  = 3'd5,
    REG_TH_FIVE  = 3'd6
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [HYST_BITS-1:0] HYST_RST     = 10'd30;
  localparam logic [CNT_BITS-1:0]  DEBOUNCE_RST = 10'd500;
  localparam mv_t                  TH_ONE_RST   = 13'd2800;
  localparam mv_t                  TH_TWO_RST   = 13'd3100;
  localparam mv_t                  TH_THREE_RST = 13'd3300;
  localparam mv_t                  TH_FOUR_RST  = 13'd3700;
  localparam mv_t                  TH_FIVE_RST  = 13'd4000;

  // Debounce counter saturates here
  localparam logic [CNT_BITS-1:0]  CNT_MAX      = '1;

endpackage

// ===== rtl/bvlt_level.sv =====
// ----------------------------------------------------------------------------
// bvlt_level
// Maps a millivolt value to the index of the first threshold it does not
// exceed. Thresholds past the programmed ones read as all ones.
// ----------------------------------------------------------------------------
module bvlt_level
  import bvlt_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = 5
) (
  input  mv_t                 mv_i,
  input  thr_arr_t            thr_i,
  output logic [LVL_BITS-1:0] level_o
);

  localparam int unsigned MAX_LEVELS = 8;

  mv_t [MAX_LEVELS-1:0] thr_ext;
  logic [3:0]           lv;
  logic                 done;

  // Extend the threshold list; unused slots are never exceeded
  always_comb begin
    thr_ext = '{default: '1};
    for (int j = 0; j < NUM_THRESH; j++) begin
      thr_ext[j] = thr_i[j];
    end
  end

  // Priority scan, first threshold not exceeded wins
  always_comb begin
    lv   = '0;
    done = 1'b0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (!done) begin
        if (mv_i <= thr_ext[k]) begin
          done = 1'b1;
        end else begin
          lv = lv + 4'd1;
        end
      end
    end
  end

  // Clamp to the field width
  assign level_o = (lv > 4'd7) ? 3'd7 : lv[LVL_BITS-1:0];

endmodule

// ===== rtl/battery_voltage_level_tracker.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_level_tracker
// Running-average battery voltage filter with hysteresis on the reported
// value and a debounced battery level lookup.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata: voltage_mv; tuser: command, force_level_update
//  m_axis   | out       | tdata: reported_mv, battery_level
//  cfg      | in        | register index and write data, always ready
//
// One sample per cycle while m_axis is not stalled. An accepted sample sits in
// an input register, the filter step is evaluated and the result lands in an
// output register. A stall on m_axis holds the output register; the input
// register still takes a new sample once it drains.
// Reset clears all filter state and loads the default register values.
// ----------------------------------------------------------------------------
module battery_voltage_level_tracker
  import bvlt_pkg::*;
#(
  parameter int unsigned AVG_SHIFT  = 5,
  parameter int unsigned NUM_LEVELS = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // sample input
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,  // [12:0] voltage_mv, [15:13] zero
  input  logic [1:0]              s_axis_tuser,  // [0] command, [1] force_level_update
  // result output
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [15:0]             m_axis_tdata,  // [12:0] reported_mv, [15:13] battery_level
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DAT_BITS-1:0] cfg_data_i
);

  localparam int unsigned SUM_BITS = VOLT_BITS + AVG_SHIFT;

  // Configuration registers
  logic [HYST_BITS-1:0] hyst_q;
  logic [CNT_BITS-1:0]  limit_q;
  thr_arr_t             thr_q;

  // Input register
  logic in_vld_q, in_vld_d;
  logic in_cmd_q, in_force_q;
  mv_t  in_mv_q;

  // Filter state
  logic [SUM_BITS-1:0] sum_q, sum_d;
  mv_t                 avg_q, avg_d;
  mv_t                 held_q, held_d;
  mv_t                 src_q, src_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [LVL_BITS-1:0] lvl_q, lvl_d;

  // Output register
  logic                out_vld_q, out_vld_d;
  mv_t                 out_mv_q;
  logic [LVL_BITS-1:0] out_lvl_q;

  logic                s_acc, advance, fire;
  logic [SUM_BITS-1:0] sum_base;
  mv_t                 avg_base;
  mv_t                 diff;
  logic [CNT_BITS-1:0] cnt_inc;
  logic [LVL_BITS-1:0] lvl_lookup;

  // Handshake
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q   <= HYST_RST;
      limit_q  <= DEBOUNCE_RST;
      thr_q[0] <= TH_ONE_RST;
      thr_q[1] <= TH_TWO_RST;
      thr_q[2] <= TH_THREE_RST;
      thr_q[3] <= TH_FOUR_RST;
      thr_q[4] <= TH_FIVE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HYST:     hyst_q   <= cfg_data_i[HYST_BITS-1:0];
        REG_DEBOUNCE: limit_q  <= cfg_data_i[CNT_BITS-1:0];
        REG_TH_ONE:   thr_q[0] <= cfg_data_i;
        REG_TH_TWO:   thr_q[1] <= cfg_data_i;
        REG_TH_THREE: thr_q[2] <= cfg_data_i;
        REG_TH_FOUR:  thr_q[3] <= cfg_data_i;
        REG_TH_FIVE:  thr_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register valid
  always_comb begin
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_cmd_q   <= s_axis_tuser[0];
      in_force_q <= s_axis_tuser[1];
      in_mv_q    <= s_axis_tdata[VOLT_BITS-1:0];
    end
  end

  // Filter step: average, hysteresis, debounce
  always_comb begin
    sum_base = in_cmd_q ? {in_mv_q, {AVG_SHIFT{1'b0}}} : sum_q;
    avg_base = in_cmd_q ? in_mv_q : avg_q;
    sum_d    = sum_base - SUM_BITS'(avg_base) + SUM_BITS'(in_mv_q);
    avg_d    = sum_d[SUM_BITS-1:AVG_SHIFT];

    diff   = (avg_d > held_q) ? (avg_d - held_q) : (held_q - avg_d);
    held_d = (diff >= VOLT_BITS'(hyst_q)) ? avg_d : held_q;

    cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    src_d   = src_q;
    lvl_d   = lvl_q;
    if (src_q != held_d) begin
      cnt_d = cnt_inc;
      if (cnt_inc > limit_q || in_force_q) begin
        cnt_d = '0;
        src_d = held_d;
        lvl_d = lvl_lookup;
      end
    end else begin
      cnt_d = '0;
    end
  end

  bvlt_level #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_level (
    .mv_i    (held_d),
    .thr_i   (thr_q),
    .level_o (lvl_lookup)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      avg_q  <= '0;
      held_q <= '0;
      src_q  <= '0;
      cnt_q  <= '0;
      lvl_q  <= '0;
    end else if (fire) begin
      sum_q  <= sum_d;
      avg_q  <= avg_d;
      held_q <= held_d;
      src_q  <= src_d;
      cnt_q  <= cnt_d;
      lvl_q  <= lvl_d;
    end
  end

  // Output register
  assign out_vld_d = fire || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_mv_q  <= held_d;
      out_lvl_q <= lvl_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_lvl_q, out_mv_q};

endmodule
